### src/gff_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gff_pkg: shared types and constants for the grid flood fill block
// Input and result transaction types, the decoded command carried from the
// front to the back, and the back status group.
// ----------------------------------------------------------------------------
package gff_pkg;

	localparam int COORD_W = 4;
	localparam int VALUE_W = 8;
	localparam int COUNT_W = 9;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 9'd511;

	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_READ  = 2'd1,
		OP_FILL  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef struct packed {
		op_t                opcode;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [VALUE_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic [VALUE_W-1:0] cell_value;
		logic [COUNT_W-1:0] changed_count;
	} out_item_t;

	typedef struct packed {
		op_t                op;
		logic               inr;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [VALUE_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic init_busy;
		logic res_valid;
	} back_status_t;

endpackage

### src/gff_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gff_front: input classification
// Decodes the opcode and checks the target address against the grid size.
// ----------------------------------------------------------------------------
module gff_front #(
	parameter int GRID_W = 16,
	parameter int GRID_H = 16
) (
	input  gff_pkg::in_item_t item,
	output gff_pkg::cmd_t     cmd
);
	import gff_pkg::*;

	logic col_ok;
	logic row_ok;

	assign col_ok = 32'(item.col) < GRID_W;
	assign row_ok = 32'(item.row) < GRID_H;

	always_comb begin
		cmd.op    = item.opcode;
		cmd.inr   = col_ok && row_ok;
		cmd.col   = item.col;
		cmd.row   = item.row;
		cmd.value = item.value;
	end

endmodule

### src/gff_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gff_queue: command queue between front and back
// Small circular buffer of decoded commands.
// ----------------------------------------------------------------------------
module gff_queue #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  gff_pkg::cmd_t  wdata,
	output logic           full,
	input  logic           pop,
	output gff_pkg::cmd_t  rdata,
	output logic           empty
);
	import gff_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	cmd_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = count_q == NW'(DEPTH);
	assign empty   = count_q == '0;
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + NW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

endmodule

### src/gff_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gff_back: grid engine
// Holds the grid memory and the pending-cell stack, runs write, read, fill
// and clear commands, and keeps one result register.
// ----------------------------------------------------------------------------
module gff_back #(
	parameter int GRID_W    = 16,
	parameter int GRID_H    = 16,
	parameter int CELL_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  q_empty,
	input  gff_pkg::cmd_t         q_data,
	output logic                  q_pop,
	input  logic                  pop,
	output gff_pkg::out_item_t    result,
	output gff_pkg::back_status_t status
);
	import gff_pkg::*;

	localparam int NCELLS = GRID_W * GRID_H;
	localparam int AW     = $clog2(NCELLS);
	localparam int TW     = $clog2(NCELLS + 1);
	localparam int CW     = $clog2(GRID_W);
	localparam int RW     = $clog2(GRID_H);
	localparam int SW     = RW + CW;

	typedef enum logic [2:0] {
		S_INIT,
		S_IDLE,
		S_LOOK,
		S_POP,
		S_SCAN,
		S_CLR
	} state_t;

	function automatic logic [AW-1:0] addr_of(input logic [RW-1:0] r, input logic [CW-1:0] c);
		addr_of = AW'(AW'(r) * AW'(GRID_W) + AW'(c));
	endfunction

	function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
		sat_inc = (v == COUNT_MAX) ? v : v + COUNT_W'(1);
	endfunction

	logic [CELL_BITS-1:0] grid_mem [NCELLS];
	logic [SW-1:0]        stk_mem [NCELLS];

	state_t               state_q;
	cmd_t                 cmd_q;
	logic [CELL_BITS-1:0] old_q;
	logic [CELL_BITS-1:0] nv_q;
	logic [COUNT_W-1:0]   cnt_q;
	logic [TW-1:0]        top_q;
	logic [2:0]           k_q;
	logic                 chk_q;
	logic [1:0]           chk_k_q;
	logic [AW-1:0]        chk_addr_q;
	logic [AW-1:0]        ptr_q;
	logic                 iss_done_q;
	out_item_t            res_q;
	logic                 res_valid_q;
	logic [CELL_BITS-1:0] g_rdata_q;
	logic [SW-1:0]        s_rdata_q;

	logic                 g_re;
	logic [AW-1:0]        g_raddr;
	logic                 g_we;
	logic [AW-1:0]        g_waddr;
	logic [CELL_BITS-1:0] g_wdata;
	logic                 s_re;
	logic [AW-1:0]        s_raddr;
	logic                 s_we;
	logic [AW-1:0]        s_waddr;
	logic [SW-1:0]        s_wdata;

	logic [CELL_BITS-1:0] cell_old;
	logic [CELL_BITS-1:0] nv;
	logic [RW-1:0]        cur_r;
	logic [CW-1:0]        cur_c;
	logic [RW-1:0]        nb_r [4];
	logic [CW-1:0]        nb_c [4];
	logic [3:0]           nb_ok;
	logic                 issue;
	logic                 hit;
	logic                 nz;
	logic                 ptr_last;
	logic [COUNT_W-1:0]   cnt_nx;

	assign q_pop    = (state_q == S_IDLE) && !q_empty && !res_valid_q;
	assign cell_old = cmd_q.inr ? g_rdata_q : '0;
	assign nv       = CELL_BITS'(cmd_q.value);
	assign ptr_last = ptr_q == AW'(NCELLS - 1);

	assign cur_r    = s_rdata_q[SW-1:CW];
	assign cur_c    = s_rdata_q[CW-1:0];
	assign nb_r[0]  = cur_r - RW'(1);
	assign nb_c[0]  = cur_c;
	assign nb_ok[0] = cur_r != '0;
	assign nb_r[1]  = cur_r + RW'(1);
	assign nb_c[1]  = cur_c;
	assign nb_ok[1] = cur_r != RW'(GRID_H - 1);
	assign nb_r[2]  = cur_r;
	assign nb_c[2]  = cur_c - CW'(1);
	assign nb_ok[2] = cur_c != '0;
	assign nb_r[3]  = cur_r;
	assign nb_c[3]  = cur_c + CW'(1);
	assign nb_ok[3] = cur_c != CW'(GRID_W - 1);

	assign issue  = !k_q[2] && nb_ok[k_q[1:0]];
	assign hit    = chk_q && (g_rdata_q == old_q);
	assign nz     = chk_q && (g_rdata_q != '0);
	assign cnt_nx = (((state_q == S_SCAN) && hit) || ((state_q == S_CLR) && nz))
		? sat_inc(cnt_q) : cnt_q;

	assign result = res_q;
	always_comb begin
		status.init_busy = state_q == S_INIT;
		status.res_valid = res_valid_q;
	end

	always_comb begin
		g_re    = 1'b0;
		g_raddr = '0;
		g_we    = 1'b0;
		g_waddr = '0;
		g_wdata = '0;
		s_re    = 1'b0;
		s_raddr = '0;
		s_we    = 1'b0;
		s_waddr = '0;
		s_wdata = '0;
		case (state_q)
			S_INIT: begin
				g_we    = 1'b1;
				g_waddr = ptr_q;
			end
			S_IDLE: begin
				g_re    = q_pop && q_data.inr;
				g_raddr = addr_of(RW'(q_data.row), CW'(q_data.col));
			end
			S_LOOK: begin
				g_waddr = addr_of(RW'(cmd_q.row), CW'(cmd_q.col));
				g_wdata = nv;
				s_waddr = '0;
				s_wdata = {RW'(cmd_q.row), CW'(cmd_q.col)};
				if (cmd_q.inr && (cmd_q.op == OP_WRITE)) begin
					g_we = 1'b1;
				end
				if (cmd_q.inr && (cmd_q.op == OP_FILL) && (cell_old != nv)) begin
					g_we = 1'b1;
					s_we = 1'b1;
				end
			end
			S_POP: begin
				s_re    = top_q != '0;
				s_raddr = AW'(top_q - TW'(1));
			end
			S_SCAN: begin
				g_re    = issue;
				g_raddr = addr_of(nb_r[k_q[1:0]], nb_c[k_q[1:0]]);
				g_we    = hit;
				g_waddr = addr_of(nb_r[chk_k_q], nb_c[chk_k_q]);
				g_wdata = nv_q;
				s_we    = hit;
				s_waddr = top_q[AW-1:0];
				s_wdata = {nb_r[chk_k_q], nb_c[chk_k_q]};
			end
			S_CLR: begin
				g_re    = !iss_done_q;
				g_raddr = ptr_q;
				g_we    = chk_q;
				g_waddr = chk_addr_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (g_we) begin
			grid_mem[g_waddr] <= g_wdata;
		end
		if (g_re) begin
			g_rdata_q <= grid_mem[g_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (s_we) begin
			stk_mem[s_waddr] <= s_wdata;
		end
		if (s_re) begin
			s_rdata_q <= stk_mem[s_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_INIT;
			cmd_q       <= '0;
			old_q       <= '0;
			nv_q        <= '0;
			cnt_q       <= '0;
			top_q       <= '0;
			k_q         <= '0;
			chk_q       <= 1'b0;
			chk_k_q     <= '0;
			chk_addr_q  <= '0;
			ptr_q       <= '0;
			iss_done_q  <= 1'b0;
			res_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (pop && res_valid_q) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_INIT: begin
					if (ptr_last) begin
						state_q <= S_IDLE;
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				S_IDLE: begin
					if (q_pop) begin
						cmd_q   <= q_data;
						state_q <= S_LOOK;
					end
				end
				S_LOOK: begin
					res_q.cell_value <= VALUE_W'(cell_old);
					case (cmd_q.op)
						OP_WRITE: begin
							res_q.changed_count <= COUNT_W'(cmd_q.inr && (cell_old != nv));
							res_valid_q         <= 1'b1;
							state_q             <= S_IDLE;
						end
						OP_FILL: begin
							if (cmd_q.inr && (cell_old != nv)) begin
								old_q   <= cell_old;
								nv_q    <= nv;
								cnt_q   <= COUNT_W'(1);
								top_q   <= TW'(1);
								state_q <= S_POP;
							end else begin
								res_q.changed_count <= '0;
								res_valid_q         <= 1'b1;
								state_q             <= S_IDLE;
							end
						end
						OP_CLEAR: begin
							cnt_q      <= '0;
							ptr_q      <= '0;
							chk_q      <= 1'b0;
							iss_done_q <= 1'b0;
							state_q    <= S_CLR;
						end
						default: begin
							res_q.changed_count <= '0;
							res_valid_q         <= 1'b1;
							state_q             <= S_IDLE;
						end
					endcase
				end
				S_POP: begin
					if (top_q == '0) begin
						res_q.changed_count <= cnt_q;
						res_valid_q         <= 1'b1;
						state_q             <= S_IDLE;
					end else begin
						top_q   <= top_q - TW'(1);
						k_q     <= '0;
						chk_q   <= 1'b0;
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (hit) begin
						top_q <= top_q + TW'(1);
					end
					cnt_q   <= cnt_nx;
					chk_q   <= issue;
					chk_k_q <= k_q[1:0];
					if (k_q[2]) begin
						state_q <= S_POP;
					end else begin
						k_q <= k_q + 3'd1;
					end
				end
				S_CLR: begin
					cnt_q      <= cnt_nx;
					chk_q      <= !iss_done_q;
					chk_addr_q <= ptr_q;
					if (iss_done_q) begin
						res_q.changed_count <= cnt_nx;
						res_valid_q         <= 1'b1;
						state_q             <= S_IDLE;
					end else if (ptr_last) begin
						iss_done_q <= 1'b1;
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

### src/grid_flood_fill_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_flood_fill_top: grid store with write, read, clear and flood fill
// Keeps a GRID_W x GRID_H grid of cells and answers every command with one
// result: the addressed cell before the command and the changed-cell count.
//
//   channel  handshake            payload
//   item     push / full          opcode, col, row, value
//   result   empty / pop          cell_value, changed_count
//
// The grid memory has one read port and one write port, which the engine
// sequences one neighbor test per cycle.
// After reset a clearing pass writes zero to every cell, with full held high.
// A two-entry command queue keeps taking transactions while a result waits.
// ----------------------------------------------------------------------------
module grid_flood_fill_top #(
	parameter int GRID_W    = 16,
	parameter int GRID_H    = 16,
	parameter int CELL_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  gff_pkg::in_item_t  item,
	output logic               empty,
	input  logic               pop,
	output gff_pkg::out_item_t result
);
	import gff_pkg::*;

	cmd_t         f_cmd;
	cmd_t         q_data;
	logic         q_full;
	logic         q_empty;
	logic         q_pop;
	logic         q_push;
	back_status_t st;

	assign full   = q_full || st.init_busy;
	assign empty  = !st.res_valid;
	assign q_push = push && !full;

	gff_front #(
		.GRID_W(GRID_W),
		.GRID_H(GRID_H)
	) u_front (
		.item(item),
		.cmd (f_cmd)
	);

	gff_queue #(
		.DEPTH(2)
	) u_queue (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (q_push),
		.wdata (f_cmd),
		.full  (q_full),
		.pop   (q_pop),
		.rdata (q_data),
		.empty (q_empty)
	);

	gff_back #(
		.GRID_W   (GRID_W),
		.GRID_H   (GRID_H),
		.CELL_BITS(CELL_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_empty(q_empty),
		.q_data (q_data),
		.q_pop  (q_pop),
		.pop    (pop),
		.result (result),
		.status (st)
	);

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_empty)
		else $error("command taken from an empty queue");

	a_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !st.res_valid)
		else $error("command started while a result is still waiting");

	a_no_start_in_init: assert property (@(posedge clk) disable iff (!arst_n)
		st.init_busy |-> !q_pop)
		else $error("command started during the clearing pass");

	a_push_lands: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |=> !q_empty)
		else $error("accepted transaction missing from the queue");

endmodule

### tb/tb_grid_flood_fill_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_flood_fill_top: self-checking bench for the grid flood fill block
// Sends write, read, fill and clear commands through the push/full side and
// checks every result taken on the empty/pop side against a cell-accurate
// model of the grid with an explicit fill stack. Directed corner commands
// come first, then random wall-drawing sequences closed by fills, with noise.
// Both sides idle at random; the result side also holds off once long
// enough to back the block up into its input.
// ----------------------------------------------------------------------------
module tb_grid_flood_fill_top;
	import gff_pkg::*;

	localparam int GRID_W         = 16;
	localparam int GRID_H         = 16;
	localparam int NCELLS         = GRID_W * GRID_H;
	localparam int ITEM_TARGET    = 580;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 100;

	logic      clk;
	logic      arst_n;
	logic      push = 1'b0;
	logic      full;
	in_item_t  item = '0;
	logic      empty;
	logic      pop = 1'b0;
	out_item_t result;

	logic [VALUE_W-1:0] grid_model [NCELLS];
	int                 region_stack [NCELLS];
	in_item_t           pending_cmds [$];
	out_item_t          expected_results [$];

	logic in_fire      = 1'b0;
	logic hold_done    = 1'b0;
	int   hold_left    = 0;
	int   items_taken  = 0;
	int   idle_cycles  = 0;
	int   errors       = 0;
	logic calm;

	grid_flood_fill_top uut (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	assign calm = (items_taken >= 300) && (items_taken < 420);

	function automatic out_item_t apply_command(in_item_t cmd);
		out_item_t o;
		int idx;
		int cnt;
		int top;
		int c;
		int n;
		int d;
		logic ok;
		logic [VALUE_W-1:0] old;
		idx = cmd.row * GRID_W + cmd.col;
		o.cell_value = grid_model[idx];
		cnt = 0;
		case (cmd.opcode)
			OP_WRITE: begin
				if (grid_model[idx] != cmd.value)
					cnt = 1;
				grid_model[idx] = cmd.value;
			end
			OP_READ: begin
			end
			OP_FILL: begin
				old = grid_model[idx];
				if (old != cmd.value) begin
					grid_model[idx] = cmd.value;
					region_stack[0] = idx;
					top = 1;
					cnt = 1;
					while (top > 0) begin
						top--;
						c = region_stack[top];
						for (d = 0; d < 4; d++) begin
							case (d)
								0: begin ok = (c / GRID_W) > 0;          n = c - GRID_W; end
								1: begin ok = (c / GRID_W) + 1 < GRID_H; n = c + GRID_W; end
								2: begin ok = (c % GRID_W) > 0;          n = c - 1;      end
								default: begin ok = (c % GRID_W) + 1 < GRID_W; n = c + 1; end
							endcase
							if (ok && grid_model[n] == old) begin
								grid_model[n] = cmd.value;
								region_stack[top] = n;
								top++;
								cnt++;
							end
						end
					end
				end
			end
			default: begin
				for (c = 0; c < NCELLS; c++) begin
					if (grid_model[c] != '0)
						cnt++;
					grid_model[c] = '0;
				end
			end
		endcase
		if (cnt > COUNT_MAX)
			cnt = COUNT_MAX;
		o.changed_count = cnt[COUNT_W-1:0];
		return o;
	endfunction

	task automatic queue_cmd(op_t op, int c, int r, int v);
		in_item_t t;
		t.opcode = op;
		t.col    = c[COORD_W-1:0];
		t.row    = r[COORD_W-1:0];
		t.value  = v[VALUE_W-1:0];
		pending_cmds.insert(pending_cmds.size(), t);
	endtask

	function automatic int pick_value();
		if ($urandom_range(0, 9) < 7)
			return $urandom_range(0, 3);
		return $urandom_range(0, 255);
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// accept side: predict each transaction taken on the input
	always @(posedge clk) begin
		if (arst_n && push && !full) begin
			expected_results.insert(expected_results.size(), apply_command(item));
			items_taken <= items_taken + 1;
			in_fire <= 1'b1;
		end else begin
			in_fire <= 1'b0;
		end
	end

	// result side: compare against the oldest prediction
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && pop && !empty) begin
			if (expected_results.size() == 0) begin
				report_mismatch("transaction with none pending", result.changed_count, 0);
			end else begin
				want = expected_results.pop_front();
				if (result.cell_value !== want.cell_value)
					report_mismatch("cell_value", result.cell_value, want.cell_value);
				if (result.changed_count !== want.changed_count)
					report_mismatch("changed_count", result.changed_count,
						want.changed_count);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty)) begin
				idle_cycles <= 0;
			end else if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	// sender: drop the accepted head, then offer the next one or idle
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_fire)
				void'(pending_cmds.pop_front());
			if (pending_cmds.size() != 0 && (calm || $urandom_range(0, 99) >= 34)) begin
				push <= 1'b1;
				item <= pending_cmds[0];
			end else begin
				push <= 1'b0;
			end
		end
	end

	// receiver: random idling plus one long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				pop <= 1'b0;
			end else if (!hold_done && items_taken >= 120) begin
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
				pop <= 1'b0;
			end else begin
				pop <= calm || ($urandom_range(0, 99) >= 34);
			end
		end
	end

	initial begin
		int i;
		int k;
		int len;
		int choice;
		int c;
		int r;
		int v;
		bit horiz;

		arst_n = 1'b0;
		for (i = 0; i < NCELLS; i++)
			grid_model[i] = '0;

		queue_cmd(OP_READ, 0, 0, 0);
		queue_cmd(OP_WRITE, 0, 0, 255);
		queue_cmd(OP_WRITE, 15, 15, 1);
		queue_cmd(OP_WRITE, 15, 0, 8'h80);
		queue_cmd(OP_WRITE, 0, 15, 8'h7f);
		queue_cmd(OP_WRITE, 0, 0, 255);
		queue_cmd(OP_WRITE, 7, 7, 0);
		queue_cmd(OP_READ, 15, 15, 0);
		queue_cmd(OP_FILL, 5, 5, 3);
		queue_cmd(OP_FILL, 5, 5, 3);
		queue_cmd(OP_FILL, 0, 0, 0);
		queue_cmd(OP_READ, 0, 0, 0);
		queue_cmd(OP_CLEAR, 15, 15, 0);
		queue_cmd(OP_CLEAR, 0, 0, 255);
		queue_cmd(OP_FILL, 15, 15, 8'haa);
		queue_cmd(OP_FILL, 0, 0, 8'h55);
		queue_cmd(OP_FILL, 8, 3, 0);
		queue_cmd(OP_READ, 15, 0, 0);
		for (i = 0; i < 16; i++)
			queue_cmd(OP_WRITE, i, 8, 9);
		queue_cmd(OP_FILL, 0, 0, 2);
		queue_cmd(OP_FILL, 15, 15, 9);
		queue_cmd(OP_CLEAR, 3, 12, 0);

		while (pending_cmds.size() < ITEM_TARGET) begin
			choice = $urandom_range(0, 99);
			if (choice < 55) begin
				len   = $urandom_range(2, 16);
				horiz = $urandom_range(0, 1);
				c     = $urandom_range(0, 15);
				r     = $urandom_range(0, 15);
				v     = pick_value();
				for (k = 0; k < len; k++) begin
					if (horiz && c + k < GRID_W)
						queue_cmd(OP_WRITE, c + k, r, v);
					else if (!horiz && r + k < GRID_H)
						queue_cmd(OP_WRITE, c, r + k, v);
				end
				queue_cmd(OP_FILL, $urandom_range(0, 15), $urandom_range(0, 15),
					pick_value());
				queue_cmd(OP_READ, $urandom_range(0, 15), $urandom_range(0, 15),
					$urandom_range(0, 255));
			end else if (choice < 90) begin
				queue_cmd(op_t'($urandom_range(0, 2)), $urandom_range(0, 15),
					$urandom_range(0, 15), pick_value());
			end else if (choice < 95) begin
				queue_cmd(OP_CLEAR, $urandom_range(0, 15), $urandom_range(0, 15),
					$urandom_range(0, 255));
			end else begin
				queue_cmd(op_t'($urandom_range(0, 3)), $urandom_range(0, 15),
					$urandom_range(0, 15), $urandom_range(0, 255));
			end
		end

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_cmds.size() != 0)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### files.f
src/gff_pkg.sv
src/gff_front.sv
src/gff_queue.sv
src/gff_back.sv
src/grid_flood_fill_top.sv
tb/tb_grid_flood_fill_top.sv
